/* rtl/salsa20_keystream_random_words_core_assert.svh */
// Assertion macros for the Salsa20 random word core.
`ifndef SALSA20_KEYSTREAM_RANDOM_WORDS_CORE_ASSERT_SVH
`define SALSA20_KEYSTREAM_RANDOM_WORDS_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SRW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SRW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/srw_pkg.sv */
// Shared types and constants for the Salsa20 random word core.
package srw_pkg;
    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    localparam logic [2:0] REG_KEY_LOW      = 3'd0;
    localparam logic [2:0] REG_KEY_MID_LOW  = 3'd1;
    localparam logic [2:0] REG_KEY_MID_HIGH = 3'd2;
    localparam logic [2:0] REG_KEY_HIGH     = 3'd3;
    localparam logic [2:0] REG_NONCE_START  = 3'd4;

    localparam logic ACTION_RAW = 1'b0;

    typedef struct packed {
        logic blk_start;    // begin Salsa20 block
        logic word_take;    // latch buffer word, decrement count
        logic div_start;    // start divider (num, den)
        logic div_min_sel;  // 1: compute threshold, 0: word mod bound
        logic out_word;     // output raw word
        logic out_rem;      // output remainder
        logic out_zero;     // output zero
    } srw_cmd_t;

    typedef struct packed {
        logic empty;
        logic blk_done;
        logic div_done;
        logic below_min;
    } srw_status_t;
endpackage

/* rtl/srw_ctrl.sv */
// Controller state machine for the Salsa20 random word core.
module srw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  logic                 action,
    input  logic                 small_bound,
    input  logic                 out_free,
    input  srw_pkg::srw_status_t sts,
    output logic                 busy,
    output srw_pkg::srw_cmd_t    cmd
);
    import srw_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MIN   = 8'b0000_0010,
        S_CHK   = 8'b0000_0100,
        S_BLK   = 8'b0000_1000,
        S_TAKE  = 8'b0001_0000,
        S_TEST  = 8'b0010_0000,
        S_MOD   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   uni_reg, uni_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            uni_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            uni_reg   <= uni_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        uni_next   = uni_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (action == ACTION_RAW)
                    begin
                        uni_next   = 1'b0;
                        state_next = S_CHK;
                    end
                    else if (small_bound)
                    begin
                        cmd.out_zero = 1'b1;
                    end
                    else
                    begin
                        uni_next        = 1'b1;
                        cmd.div_start   = 1'b1;
                        cmd.div_min_sel = 1'b1;
                        state_next      = S_MIN;
                    end
                end
            end
            S_MIN:
            begin
                if (sts.div_done)
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                if (sts.empty)
                begin
                    cmd.blk_start = 1'b1;
                    state_next    = S_BLK;
                end
                else
                    state_next = S_TAKE;
            end
            S_BLK:
            begin
                if (sts.blk_done)
                    state_next = S_TAKE;
            end
            S_TAKE:
            begin
                cmd.word_take = 1'b1;
                state_next    = uni_reg ? S_TEST : S_OUT;
            end
            S_TEST:
            begin
                if (sts.below_min)
                    state_next = S_CHK;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_MOD;
                end
            end
            S_MOD:
            begin
                if (sts.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_word = !uni_reg;
                    cmd.out_rem  = uni_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end
endmodule

/* rtl/srw_datapath.sv */
// Salsa20 core, word buffer and restoring divider.
module srw_datapath #(
    parameter int ROUNDS = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  srw_pkg::srw_cmd_t    cmd,
    input  logic [31:0]          limit,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [63:0]          cfg_data,
    output srw_pkg::srw_status_t sts,
    output logic [31:0]          word,
    output logic [31:0]          rem
);
    import srw_pkg::*;

    localparam int RW = $clog2(ROUNDS + 1);

    logic [63:0] key_reg [4];
    logic [63:0] nstart_reg, nonce_reg;
    logic [4:0]  left_reg;
    logic [31:0] buf_reg [16];
    logic [31:0] x_reg [16];
    logic [31:0] xn [16];
    logic [31:0] init [16];
    logic [RW-1:0] rnd_reg;
    logic        blk_busy_reg, blk_done;
    logic [31:0] bound_reg, min_reg, word_reg;
    logic [31:0] q_reg, r_reg;
    logic [5:0]  dcnt_reg;
    logic        dbusy_reg, dmin_reg, ddone_reg;
    logic [32:0] trial;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [127:0] qr(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
        logic [31:0] b1, c1, d1, a1;
        b1 = b ^ rotl(a + d, 7);
        c1 = c ^ rotl(b1 + a, 9);
        d1 = d ^ rotl(c1 + b1, 13);
        a1 = a ^ rotl(d1 + c1, 18);
        qr = {a1, b1, c1, d1};
    endfunction

    always_comb
    begin
        init[0]  = SIGMA0;
        init[1]  = key_reg[0][31:0];
        init[2]  = key_reg[0][63:32];
        init[3]  = key_reg[1][31:0];
        init[4]  = key_reg[1][63:32];
        init[5]  = SIGMA1;
        init[6]  = nonce_reg[31:0];
        init[7]  = nonce_reg[63:32];
        init[8]  = '0;
        init[9]  = '0;
        init[10] = SIGMA2;
        init[11] = key_reg[2][31:0];
        init[12] = key_reg[2][63:32];
        init[13] = key_reg[3][31:0];
        init[14] = key_reg[3][63:32];
        init[15] = SIGMA3;
    end

    // one column or row round per cycle
    always_comb
    begin
        for (int i = 0; i < 16; i++)
            xn[i] = x_reg[i];
        if (!rnd_reg[0])
        begin
            {xn[0], xn[4], xn[8], xn[12]}  = qr(x_reg[0], x_reg[4], x_reg[8], x_reg[12]);
            {xn[5], xn[9], xn[13], xn[1]}  = qr(x_reg[5], x_reg[9], x_reg[13], x_reg[1]);
            {xn[10], xn[14], xn[2], xn[6]} = qr(x_reg[10], x_reg[14], x_reg[2], x_reg[6]);
            {xn[15], xn[3], xn[7], xn[11]} = qr(x_reg[15], x_reg[3], x_reg[7], x_reg[11]);
        end
        else
        begin
            {xn[0], xn[1], xn[2], xn[3]}     = qr(x_reg[0], x_reg[1], x_reg[2], x_reg[3]);
            {xn[5], xn[6], xn[7], xn[4]}     = qr(x_reg[5], x_reg[6], x_reg[7], x_reg[4]);
            {xn[10], xn[11], xn[8], xn[9]}   = qr(x_reg[10], x_reg[11], x_reg[8], x_reg[9]);
            {xn[15], xn[12], xn[13], xn[14]} = qr(x_reg[15], x_reg[12], x_reg[13], x_reg[14]);
        end
    end

    assign blk_done = blk_busy_reg && (rnd_reg == RW'(ROUNDS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                key_reg[i] <= '0;
            nstart_reg   <= 64'd1;
            nonce_reg    <= 64'd1;
            left_reg     <= '0;
            blk_busy_reg <= 1'b0;
            rnd_reg      <= '0;
        end
        else if (cfg_we && (cfg_index <= REG_NONCE_START))
        begin
            case (cfg_index)
                REG_KEY_LOW:      key_reg[0] <= cfg_data;
                REG_KEY_MID_LOW:  key_reg[1] <= cfg_data;
                REG_KEY_MID_HIGH: key_reg[2] <= cfg_data;
                REG_KEY_HIGH:     key_reg[3] <= cfg_data;
                default:          nstart_reg <= cfg_data;
            endcase
            nonce_reg <= (cfg_index == REG_NONCE_START) ? cfg_data : nstart_reg;
            left_reg  <= '0;
        end
        else
        begin
            if (cmd.blk_start)
            begin
                blk_busy_reg <= 1'b1;
                rnd_reg      <= '0;
            end
            else if (blk_done)
            begin
                blk_busy_reg <= 1'b0;
                nonce_reg    <= nonce_reg + 64'd1;
                left_reg     <= 5'd16;
            end
            else if (blk_busy_reg)
                rnd_reg <= rnd_reg + RW'(1);
            if (cmd.word_take)
                left_reg <= left_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.blk_start)
            for (int i = 0; i < 16; i++)
                x_reg[i] <= init[i];
        else if (blk_busy_reg && !blk_done)
            for (int i = 0; i < 16; i++)
                x_reg[i] <= xn[i];
        if (blk_done)
            for (int i = 0; i < 16; i++)
                buf_reg[i] <= x_reg[i] + init[i];
        if (cmd.word_take)
            word_reg <= buf_reg[left_reg[3:0] - 4'd1];
    end

    // restoring divider, one quotient bit per cycle
    assign trial = {r_reg, q_reg[31]} - {1'b0, bound_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            ddone_reg <= 1'b0;
            dcnt_reg  <= '0;
        end
        else
        begin
            ddone_reg <= 1'b0;
            if (cmd.div_start)
            begin
                dbusy_reg <= 1'b1;
                dcnt_reg  <= '0;
            end
            else if (dbusy_reg)
            begin
                dcnt_reg <= dcnt_reg + 6'd1;
                if (dcnt_reg == 6'd31)
                begin
                    dbusy_reg <= 1'b0;
                    ddone_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            r_reg    <= '0;
            dmin_reg <= cmd.div_min_sel;
            if (cmd.div_min_sel)
            begin
                bound_reg <= limit;
                q_reg     <= 32'd0 - limit;
            end
            else
                q_reg <= word_reg;
        end
        else if (dbusy_reg)
        begin
            if (!trial[32])
            begin
                r_reg <= trial[31:0];
                q_reg <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[30:0], q_reg[31]};
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
        if (ddone_reg && dmin_reg)
            min_reg <= r_reg;
    end

    assign sts.empty     = (left_reg == 5'd0) || (left_reg > 5'd16);
    assign sts.blk_done  = blk_done;
    assign sts.div_done  = ddone_reg;
    assign sts.below_min = (word_reg < min_reg);
    assign word = word_reg;
    assign rem  = r_reg;
endmodule

/* rtl/salsa20_keystream_random_words_core.sv */
// Top level of the Salsa20 keystream random word core.
//
// channel  dir  handshake          payload
// s_axis   in   tvalid/tready      tdata[0] action, tdata[32:1] bound
// m_axis   out  tvalid/tready      tdata[31:0] value
// cfg      in   cfg_we             cfg_index, cfg_data
//
// Raw word: read from the buffer; an empty buffer first gets a block, one round a cycle.
// Uniform: threshold first; words below it are rejected (block refill when empty), then the
// remainder is loaded for output (32-step divider). Small bound answers 0 at acceptance.
// Reset clears control state; buffer contents are undefined until a block is made.
// One output register; input is held off while a result waits in it.
module salsa20_keystream_random_words_core #(
    parameter int ROUNDS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // action, bound, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // value
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import srw_pkg::*;

    srw_cmd_t    cmd;
    srw_status_t sts;
    logic        busy, in_fire, out_free, small_bound;
    logic [31:0] word, rem;
    logic        ov_reg;
    logic [31:0] od_reg;

    assign out_free      = !ov_reg || m_axis_tready;
    assign s_axis_tready = !busy && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign small_bound   = (s_axis_tdata[32:1] < 32'd2);

    srw_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .action(s_axis_tdata[0]),
        .small_bound(small_bound), .out_free(out_free), .sts(sts),
        .busy(busy), .cmd(cmd)
    );

    srw_datapath #(.ROUNDS(ROUNDS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .limit(s_axis_tdata[32:1]),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .sts(sts), .word(word), .rem(rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.out_word || cmd.out_rem || cmd.out_zero)
            ov_reg <= 1'b1;
        else if (m_axis_tready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_word)
            od_reg <= word;
        else if (cmd.out_rem)
            od_reg <= rem;
        else if (cmd.out_zero)
            od_reg <= '0;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;

    `include "salsa20_keystream_random_words_core_assert.svh"

    `SRW_ASSERT_IMP(a_no_in_when_busy, busy, !s_axis_tready)
    `SRW_ASSERT_IMP(a_load_needs_room, cmd.out_word || cmd.out_rem || cmd.out_zero, out_free)
    `SRW_ASSERT_NEXT(a_out_set, cmd.out_word || cmd.out_rem || cmd.out_zero, m_axis_tvalid)
endmodule

/* test/salsa20_keystream_random_words_core_test.sv */
// Self-checking testbench for the Salsa20 keystream random word core.
`timescale 1ns / 1ps

module salsa20_keystream_random_words_core_test;
    import srw_pkg::*;

    localparam logic       ACTION_UNIFORM = ~ACTION_RAW;
    localparam logic [2:0] REG_UNUSED     = 3'd7;
    localparam int         IDLE_LIMIT     = 20000;
    localparam int         DRAIN_CYCLES   = 80;
    localparam int         HOLD_CYCLES    = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    salsa20_keystream_random_words_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // predictor state
    logic [63:0] key_reg [4];
    logic [63:0] nonce_reg;
    logic [63:0] blk_nonce;
    logic [31:0] ks_buf [16];
    logic [31:0] salsa_x [16];
    int          words_left;

    logic [31:0] expected_values [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          hold_req = 1'b0;
    bit          no_idle = 1'b0;

    function automatic logic [31:0] rotl(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void quarter(int a, int b, int c, int d);
        salsa_x[b] ^= rotl(salsa_x[a] + salsa_x[d], 7);
        salsa_x[c] ^= rotl(salsa_x[b] + salsa_x[a], 9);
        salsa_x[d] ^= rotl(salsa_x[c] + salsa_x[b], 13);
        salsa_x[a] ^= rotl(salsa_x[d] + salsa_x[c], 18);
    endfunction

    function automatic void make_block();
        logic [31:0] init [16];
        init[0]  = SIGMA0;
        init[1]  = key_reg[0][31:0];
        init[2]  = key_reg[0][63:32];
        init[3]  = key_reg[1][31:0];
        init[4]  = key_reg[1][63:32];
        init[5]  = SIGMA1;
        init[6]  = blk_nonce[31:0];
        init[7]  = blk_nonce[63:32];
        init[8]  = '0;
        init[9]  = '0;
        init[10] = SIGMA2;
        init[11] = key_reg[2][31:0];
        init[12] = key_reg[2][63:32];
        init[13] = key_reg[3][31:0];
        init[14] = key_reg[3][63:32];
        init[15] = SIGMA3;
        for (int i = 0; i < 16; i++) salsa_x[i] = init[i];
        for (int r = 0; r < 20; r++) begin
            if (r % 2 == 0) begin
                quarter(0, 4, 8, 12);
                quarter(5, 9, 13, 1);
                quarter(10, 14, 2, 6);
                quarter(15, 3, 7, 11);
            end
            else begin
                quarter(0, 1, 2, 3);
                quarter(5, 6, 7, 4);
                quarter(10, 11, 8, 9);
                quarter(15, 12, 13, 14);
            end
        end
        for (int i = 0; i < 16; i++) ks_buf[i] = salsa_x[i] + init[i];
        blk_nonce  = blk_nonce + 64'd1;
        words_left = 16;
    endfunction

    function automatic logic [31:0] draw_word();
        if (words_left == 0) make_block();
        words_left--;
        return ks_buf[words_left];
    endfunction

    function automatic logic [31:0] predict_value(logic act, logic [31:0] bound);
        logic [31:0] thresh;
        logic [31:0] w;
        if (act == ACTION_RAW) return draw_word();
        if (bound < 32'd2) return 32'd0;
        thresh = (32'd0 - bound) % bound;
        do w = draw_word(); while (w < thresh);
        return w % bound;
    endfunction

    task automatic send_item(logic act, logic [31:0] bound);
        int  gap;
        bit  ok;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        expected_values.push_back(predict_value(act, bound));
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, bound, act};
        do begin
            @(negedge clk);
            ok = s_axis_tready;
            @(posedge clk);
        end while (!ok);
    endtask

    task automatic stop_input();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_results();
        stop_input();
        wait (expected_values.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        wait_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx <= REG_NONCE_START) begin
            if (idx == REG_NONCE_START) nonce_reg = val;
            else key_reg[idx] = val;
            words_left = 0;
            blk_nonce  = nonce_reg;
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [31:0] rand_bound();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1);
            1: return $urandom_range(2, 20);
            2: return (32'd1 << $urandom_range(1, 31)) + $urandom_range(0, 2) - 1;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 4) send_item(ACTION_RAW, $urandom());
            else send_item(ACTION_UNIFORM, rand_bound());
        end
    endtask

    task automatic test_directed();
        send_item(ACTION_RAW, 32'd0);
        send_item(ACTION_RAW, 32'hFFFF_FFFF);
        send_item(ACTION_UNIFORM, 32'd0);
        send_item(ACTION_UNIFORM, 32'd1);
        send_item(ACTION_UNIFORM, 32'd2);
        send_item(ACTION_UNIFORM, 32'd3);
        send_item(ACTION_UNIFORM, 32'h8000_0000);
        send_item(ACTION_UNIFORM, 32'h8000_0001);
        send_item(ACTION_UNIFORM, 32'hFFFF_FFFF);
        send_item(ACTION_UNIFORM, 32'hFFFF_FFFE);
        for (int i = 0; i < 14; i++) send_item(ACTION_RAW, 32'h5555_5555);
    endtask

    task automatic test_config_extremes();
        for (int r = 0; r < 4; r++) write_reg(r[2:0], '1);
        write_reg(REG_NONCE_START, '1);     // nonce wraps after one block
        send_random(20);
        write_reg(REG_NONCE_START, '0);     // zero nonce taken as is
        send_random(6);
        send_item(ACTION_RAW, 32'd0);
        wait_results();
        cfg_we    <= 1'b1;                  // out of range index, no effect
        cfg_index <= REG_UNUSED;
        cfg_data  <= rand64();
        @(posedge clk);
        cfg_we <= 1'b0;
        send_random(8);
        for (int r = 0; r < 4; r++) write_reg(r[2:0], '0);
        write_reg(REG_NONCE_START, 64'd1);
        send_random(10);
    endtask

    task automatic test_random();
        for (int p = 0; p < 6; p++) begin
            for (int r = 0; r < 4; r++) write_reg(r[2:0], rand64());
            write_reg(REG_NONCE_START, rand64());
            no_idle = (p == 2);
            send_random(230);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        no_idle  = 1'b1;
        send_random(40);
        no_idle  = 1'b0;
        wait_results();
        send_random(30);
    endtask

    // result checker with random ready
    initial begin
        int          n;
        bit          got;
        logic [31:0] data;
        logic [31:0] want;
        @(posedge rst_n);
        forever begin
            if (hold_req) begin
                n = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else n = no_idle ? 0 : $urandom_range(0, 8);
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do begin
                @(negedge clk);
                got  = m_axis_tvalid;
                data = m_axis_tdata;
                @(posedge clk);
            end while (!got);
            if (expected_values.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction: value %h", data);
            end
            else begin
                want = expected_values.pop_front();
                if (data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("value mismatch: expected %h actual %h", want, data);
                end
            end
        end
    end

    initial begin
        forever begin
            @(negedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("salsa20_keystream_random_words_core: mismatch");
                $finish;
            end
        end
    end

    initial begin
        for (int r = 0; r < 4; r++) key_reg[r] = '0;
        nonce_reg  = 64'd1;
        blk_nonce  = 64'd1;
        words_left = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random();
        wait_results();
        if (mismatches == 0 && expected_values.size() == 0)
            $display("salsa20_keystream_random_words_core: match");
        else
            $display("salsa20_keystream_random_words_core: mismatch");
        $finish;
    end
endmodule
